/* design/bcc_pkg.sv */
// Package for the battery charge controller.
// Holds field widths, command, mode, reason and register codes and shared structs.
// No dependencies.
package bcc_pkg;

	localparam int KIND_W   = 2;
	localparam int MINUTE_W = 12;
	localparam int MEAS_W   = 16;
	localparam int RAW_W    = 10;
	localparam int DUTY_W   = 8;
	localparam int REASON_W = 4;
	localparam int OVRUN_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

	// chemistry modes
	localparam logic [1:0] MODE_NICKEL = 2'd0;
	localparam logic [1:0] MODE_SLA    = 2'd1;

	// end reasons
	localparam logic [REASON_W-1:0] RSN_NONE     = 4'd0;
	localparam logic [REASON_W-1:0] RSN_TIMEOUT  = 4'd1;
	localparam logic [REASON_W-1:0] RSN_OVERVOLT = 4'd2;
	localparam logic [REASON_W-1:0] RSN_MINUS_DV = 4'd3;
	localparam logic [REASON_W-1:0] RSN_DT       = 4'd4;
	localparam logic [REASON_W-1:0] RSN_TAPER    = 4'd5;
	localparam logic [REASON_W-1:0] RSN_HOT      = 4'd6;
	localparam logic [REASON_W-1:0] RSN_COLD     = 4'd7;
	localparam logic [REASON_W-1:0] RSN_USER     = 4'd8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHEM_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLTAGE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CV_VOLTAGE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CC_CURRENT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FINAL_CURRENT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN      = 3'd7;

	// minutes before the falling voltage test is armed
	localparam logic [MINUTE_W-1:0] NDV_WAIT_MINUTES = 12'd10;

	localparam logic [DUTY_W-1:0]  DUTY_MAX   = 8'd255;
	localparam logic [OVRUN_W-1:0] OVRUN_MAX  = 3'd7;
	localparam logic [OVRUN_W-1:0] OVRUN_TRIP = 3'd4;
	localparam logic [RAW_W:0]     DT_RISE    = 11'd3;

	typedef struct packed {
		logic [1:0]          chem_mode;
		logic [MINUTE_W-1:0] timeout_minutes;
		logic [MEAS_W-1:0]   max_voltage;
		logic [MEAS_W-1:0]   cv_voltage;
		logic [MEAS_W-1:0]   cc_current;
		logic [MEAS_W-1:0]   final_current;
		logic [RAW_W-1:0]    temp_max;
		logic [RAW_W-1:0]    temp_min;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [MINUTE_W-1:0] minute_count;
		logic [MEAS_W-1:0]   batt_voltage;
		logic [MEAS_W-1:0]   batt_current;
		logic [RAW_W-1:0]    batt_temp;
		logic [RAW_W-1:0]    raw_voltage;
		logic [RAW_W-1:0]    raw_temp;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]   duty;
		logic [OVRUN_W-1:0]  ov_run;
		logic [MINUTE_W-1:0] seen_minute;
		logic [RAW_W-1:0]    prior_rv;
		logic [RAW_W-1:0]    prior_rt;
		logic                cv_phase;
		logic                halted;
		logic [REASON_W-1:0] reason;
	} state_t;

endpackage

/* design/bcc_if.sv */
// Handshake channels of the battery charge controller: sample input and result output.
// Depends on bcc_pkg for field widths.
interface bcc_in_if;
	logic                                valid;
	logic                                ready;
	logic [bcc_pkg::KIND_W-1:0]          kind;
	logic [bcc_pkg::MINUTE_W-1:0]        minute_count;
	logic [bcc_pkg::MEAS_W-1:0]          batt_voltage;
	logic [bcc_pkg::MEAS_W-1:0]          batt_current;
	logic [bcc_pkg::RAW_W-1:0]           batt_temp;
	logic [bcc_pkg::RAW_W-1:0]           raw_voltage;
	logic [bcc_pkg::RAW_W-1:0]           raw_temp;

	modport source(output valid, kind, minute_count, batt_voltage, batt_current,
		batt_temp, raw_voltage, raw_temp, input ready);
	modport sink(input valid, kind, minute_count, batt_voltage, batt_current,
		batt_temp, raw_voltage, raw_temp, output ready);
endinterface

interface bcc_out_if;
	logic                           valid;
	logic                           ready;
	logic [bcc_pkg::DUTY_W-1:0]     duty_out;
	logic                           stopped_out;
	logic [bcc_pkg::REASON_W-1:0]   end_reason;
	logic                           phase_out;

	modport source(output valid, duty_out, stopped_out, end_reason, phase_out,
		input ready);
	modport sink(input valid, duty_out, stopped_out, end_reason, phase_out,
		output ready);
endinterface

/* design/battery_charge_controller.sv */
// Battery charge controller: each transfer on the sample channel (start, measurement
// or user stop) yields exactly one result transfer with the PWM duty, the stopped
// flag, the kept end reason and the charge phase after that item. An accepted item
// sits in the input register until the result register is free, then the step logic
// updates the charger state and loads the result register, so one item is taken every
// cycle unless the result side stalls; only a stalled result register holds the input
// side. Write configuration only while no item is in flight.
// Depends on bcc_pkg, bcc_if, bcc_cfg_regs and bcc_step.
module battery_charge_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	bcc_in_if.sink                          sample,
	bcc_out_if.source                       result,
	input  logic                            cfg_we,
	input  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	bcc_pkg::cfg_t   cfg;
	bcc_pkg::state_t st_q;
	bcc_pkg::state_t st_nxt;
	bcc_pkg::item_t  item_s1;
	logic            valid_s1;
	logic            res_valid_q;
	logic            adv;
	bcc_pkg::state_t res_q;

	bcc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	bcc_step u_step (
		.cfg  (cfg),
		.st   (st_q),
		.item (item_s1),
		.nxt  (st_nxt)
	);

	// advance the held item once the result register is free
	assign adv          = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (sample.ready)
			valid_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1.kind         <= sample.kind;
			item_s1.minute_count <= sample.minute_count;
			item_s1.batt_voltage <= sample.batt_voltage;
			item_s1.batt_current <= sample.batt_current;
			item_s1.batt_temp    <= sample.batt_temp;
			item_s1.raw_voltage  <= sample.raw_voltage;
			item_s1.raw_temp     <= sample.raw_temp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			st_q        <= st_nxt;
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= st_nxt;
	end

	assign result.valid       = res_valid_q;
	assign result.duty_out    = res_q.duty;
	assign result.stopped_out = res_q.halted;
	assign result.end_reason  = res_q.reason;
	assign result.phase_out   = res_q.cv_phase;

	a_stop_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.stopped_out |-> result.duty_out == '0)
		else $error("stopped result with nonzero duty");

	a_halt_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |-> st_q.reason != bcc_pkg::RSN_NONE)
		else $error("halted without an end reason");

	a_reason_kept: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted && !(adv && item_s1.kind == bcc_pkg::KIND_START)
		|=> st_q.reason == $past(st_q.reason))
		else $error("end reason changed while halted");

	a_item_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !res_valid_q |=> res_valid_q)
		else $error("held item did not reach the result register");

endmodule

/* design/bcc_cfg_regs.sv */
// Configuration register file of the battery charge controller.
// Depends on bcc_pkg for the register indexes and the cfg_t struct.
module bcc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [bcc_pkg::CFG_IDX_W-1:0]     idx,
	input  logic [bcc_pkg::CFG_DATA_W-1:0]    wdata,
	output bcc_pkg::cfg_t                     cfg
);

	bcc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chem_mode       <= bcc_pkg::MODE_NICKEL;
			cfg_q.timeout_minutes <= 12'd65;
			cfg_q.max_voltage     <= 16'hFFFF;
			cfg_q.cv_voltage      <= '0;
			cfg_q.cc_current      <= '0;
			cfg_q.final_current   <= '0;
			cfg_q.temp_max        <= 10'd1023;
			cfg_q.temp_min        <= '0;
		end else if (we) begin
			case (idx)
				bcc_pkg::CFG_CHEM_MODE:     cfg_q.chem_mode       <= wdata[1:0];
				bcc_pkg::CFG_TIMEOUT:       cfg_q.timeout_minutes <= wdata[11:0];
				bcc_pkg::CFG_MAX_VOLTAGE:   cfg_q.max_voltage     <= wdata;
				bcc_pkg::CFG_CV_VOLTAGE:    cfg_q.cv_voltage      <= wdata;
				bcc_pkg::CFG_CC_CURRENT:    cfg_q.cc_current      <= wdata;
				bcc_pkg::CFG_FINAL_CURRENT: cfg_q.final_current   <= wdata;
				bcc_pkg::CFG_TEMP_MAX:      cfg_q.temp_max        <= wdata[9:0];
				bcc_pkg::CFG_TEMP_MIN:      cfg_q.temp_min        <= wdata[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/bcc_step.sv */
// Next-state logic of the battery charge controller for one item.
// Pure combinational; depends on bcc_pkg for cfg_t, item_t, state_t and codes.
module bcc_step (
	input  bcc_pkg::cfg_t   cfg,
	input  bcc_pkg::state_t st,
	input  bcc_pkg::item_t  item,
	output bcc_pkg::state_t nxt
);

	function automatic bcc_pkg::state_t halt_with(input bcc_pkg::state_t s,
			input logic [bcc_pkg::REASON_W-1:0] r);
		bcc_pkg::state_t o;
		o = s;
		o.duty   = '0;
		o.halted = 1'b1;
		if (o.reason == bcc_pkg::RSN_NONE)
			o.reason = r;
		return o;
	endfunction

	function automatic logic [bcc_pkg::DUTY_W-1:0] regulate(
			input logic [bcc_pkg::DUTY_W-1:0] d,
			input logic [bcc_pkg::MEAS_W-1:0] meas,
			input logic [bcc_pkg::MEAS_W-1:0] target);
		logic [bcc_pkg::DUTY_W-1:0] o;
		o = d;
		if (meas < target) begin
			if (d != bcc_pkg::DUTY_MAX)
				o = d + 8'd1;
		end else if (meas > target) begin
			if (d != '0)
				o = d - 8'd1;
		end
		return o;
	endfunction

	bcc_pkg::state_t s;
	logic            done;
	logic [bcc_pkg::RAW_W:0] rt_limit;

	always_comb begin
		s        = st;
		done     = 1'b0;
		rt_limit = {1'b0, st.prior_rt} + bcc_pkg::DT_RISE;
		case (item.kind)
			bcc_pkg::KIND_START: begin
				s = '0;
			end
			bcc_pkg::KIND_STOP: begin
				s = halt_with(s, bcc_pkg::RSN_USER);
			end
			bcc_pkg::KIND_SAMPLE: begin
				if (!st.halted) begin
					if (cfg.chem_mode == bcc_pkg::MODE_NICKEL) begin
						if (item.minute_count > cfg.timeout_minutes) begin
							s    = halt_with(s, bcc_pkg::RSN_TIMEOUT);
							done = 1'b1;
						end else begin
							if (item.batt_voltage >= cfg.max_voltage) begin
								if (s.ov_run < bcc_pkg::OVRUN_MAX)
									s.ov_run = s.ov_run + 3'd1;
								if (s.ov_run >= bcc_pkg::OVRUN_TRIP) begin
									s    = halt_with(s, bcc_pkg::RSN_OVERVOLT);
									done = 1'b1;
								end
							end else begin
								s.ov_run = '0;
							end
							// slope tests run once per new minute
							if (!done && item.minute_count != st.seen_minute) begin
								s.seen_minute = item.minute_count;
								if (item.minute_count >= bcc_pkg::NDV_WAIT_MINUTES &&
										st.prior_rv != '0 && item.raw_voltage < st.prior_rv) begin
									s    = halt_with(s, bcc_pkg::RSN_MINUS_DV);
									done = 1'b1;
								end else begin
									s.prior_rv = item.raw_voltage;
									if (st.prior_rt != '0 && {1'b0, item.raw_temp} >= rt_limit) begin
										s    = halt_with(s, bcc_pkg::RSN_DT);
										done = 1'b1;
									end else begin
										s.prior_rt = item.raw_temp;
									end
								end
							end
							if (!done)
								s.duty = regulate(s.duty, item.batt_current, cfg.cc_current);
						end
					end else begin
						if (cfg.chem_mode == bcc_pkg::MODE_SLA &&
								item.minute_count > cfg.timeout_minutes) begin
							s = halt_with(s, bcc_pkg::RSN_TIMEOUT);
						end else if (item.batt_voltage >= cfg.max_voltage && !st.cv_phase) begin
							// enter constant voltage: drop duty by two
							s.duty     = (st.duty < 8'd2) ? '0 : st.duty - 8'd2;
							s.cv_phase = 1'b1;
						end else if (!st.cv_phase) begin
							s.duty = regulate(s.duty, item.batt_current, cfg.cc_current);
						end else begin
							s.duty = regulate(s.duty, item.batt_voltage, cfg.cv_voltage);
							if (item.batt_current < cfg.final_current)
								s = halt_with(s, bcc_pkg::RSN_TAPER);
						end
					end
					if (item.batt_temp > cfg.temp_max)
						s = halt_with(s, bcc_pkg::RSN_HOT);
					else if (item.batt_temp < cfg.temp_min)
						s = halt_with(s, bcc_pkg::RSN_COLD);
				end
			end
			default: ;
		endcase
	end

	assign nxt = s;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for battery_charge_controller: directed stimulus table, then random
// charge sessions over several register settings, checked against an in-bench charger model.
// Depends on bcc_pkg, bcc_if and the controller RTL.
module tb;

	typedef logic [bcc_pkg::KIND_W-1:0]     kind_t;
	typedef logic [bcc_pkg::MINUTE_W-1:0]   minute_t;
	typedef logic [bcc_pkg::MEAS_W-1:0]     meas_t;
	typedef logic [bcc_pkg::RAW_W-1:0]      raw_t;
	typedef logic [bcc_pkg::CFG_IDX_W-1:0]  idx_t;
	typedef logic [bcc_pkg::CFG_DATA_W-1:0] word_t;

	localparam logic [1:0] MODE_LITHIUM = 2'd2;
	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam kind_t      KIND_SPARE   = 2'd3;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 70;
	localparam int SETTLE       = 4;

	typedef struct packed {
		logic [bcc_pkg::DUTY_W-1:0]   duty;
		logic                         stopped;
		logic [bcc_pkg::REASON_W-1:0] reason;
		logic                         phase;
	} outcome_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_e;

	typedef struct packed {
		row_e            op;
		bcc_pkg::item_t  it;
		bcc_pkg::cfg_t   cfg;
		logic            typed;
		outcome_t        want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	idx_t  cfg_idx;
	word_t cfg_wdata;

	bcc_in_if  sample();
	bcc_out_if result();

	battery_charge_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// charger model: register copy and state
	bcc_pkg::cfg_t                limits;
	logic [bcc_pkg::DUTY_W-1:0]   duty_now;
	logic [bcc_pkg::OVRUN_W-1:0]  ov_run;
	minute_t                      last_minute;
	raw_t                         prev_rv;
	raw_t                         prev_rt;
	logic                         cv_mode;
	logic                         stopped;
	logic [bcc_pkg::REASON_W-1:0] kept_reason;

	outcome_t pending_outcomes[$];
	row_t     plan[$];
	int errors = 0;
	int quiet = 0;
	int stall_left = 0;
	bit gap_en = 1'b1;
	bit stall_en = 1'b1;

	// random charge session
	minute_t s_min;
	int s_rv, s_rt, s_over;

	function void halt_charge(input logic [bcc_pkg::REASON_W-1:0] why);
		duty_now = '0;
		stopped = 1'b1;
		if (kept_reason == bcc_pkg::RSN_NONE)
			kept_reason = why;
	endfunction

	function void steer(input meas_t meas, input meas_t target);
		if (meas < target) begin
			if (duty_now != bcc_pkg::DUTY_MAX)
				duty_now++;
		end else if (meas > target) begin
			if (duty_now != '0)
				duty_now--;
		end
	endfunction

	function void nickel_update(input bcc_pkg::item_t it);
		if (it.minute_count > limits.timeout_minutes) begin
			halt_charge(bcc_pkg::RSN_TIMEOUT);
			return;
		end
		if (it.batt_voltage >= limits.max_voltage) begin
			if (ov_run < bcc_pkg::OVRUN_MAX)
				ov_run++;
			if (ov_run >= bcc_pkg::OVRUN_TRIP) begin
				halt_charge(bcc_pkg::RSN_OVERVOLT);
				return;
			end
		end else begin
			ov_run = '0;
		end
		// slope tests run once per new minute; a zero prior reading disarms them
		if (it.minute_count != last_minute) begin
			last_minute = it.minute_count;
			if (it.minute_count >= bcc_pkg::NDV_WAIT_MINUTES && prev_rv != '0 &&
				it.raw_voltage < prev_rv) begin
				halt_charge(bcc_pkg::RSN_MINUS_DV);
				return;
			end
			prev_rv = it.raw_voltage;
			if (prev_rt != '0 && int'(it.raw_temp) >= int'(prev_rt) + 3) begin
				halt_charge(bcc_pkg::RSN_DT);
				return;
			end
			prev_rt = it.raw_temp;
		end
		steer(it.batt_current, limits.cc_current);
	endfunction

	function void lead_lithium_update(input bcc_pkg::item_t it);
		if (limits.chem_mode == bcc_pkg::MODE_SLA &&
			it.minute_count > limits.timeout_minutes) begin
			halt_charge(bcc_pkg::RSN_TIMEOUT);
			return;
		end
		if (it.batt_voltage >= limits.max_voltage && !cv_mode) begin
			duty_now = (duty_now < 8'd2) ? '0 : duty_now - 8'd2;
			cv_mode = 1'b1;
			return;
		end
		if (!cv_mode) begin
			steer(it.batt_current, limits.cc_current);
		end else begin
			steer(it.batt_voltage, limits.cv_voltage);
			if (it.batt_current < limits.final_current)
				halt_charge(bcc_pkg::RSN_TAPER);
		end
	endfunction

	function outcome_t charger_step(input bcc_pkg::item_t it);
		case (it.kind)
			bcc_pkg::KIND_START: begin
				duty_now = '0;
				ov_run = '0;
				last_minute = '0;
				prev_rv = '0;
				prev_rt = '0;
				cv_mode = 1'b0;
				stopped = 1'b0;
				kept_reason = bcc_pkg::RSN_NONE;
			end
			bcc_pkg::KIND_STOP: halt_charge(bcc_pkg::RSN_USER);
			bcc_pkg::KIND_SAMPLE: begin
				if (!stopped) begin
					if (limits.chem_mode == bcc_pkg::MODE_NICKEL)
						nickel_update(it);
					else
						lead_lithium_update(it);
					// limits apply even when the mode step just ended the charge
					if (it.batt_temp > limits.temp_max)
						halt_charge(bcc_pkg::RSN_HOT);
					else if (it.batt_temp < limits.temp_min)
						halt_charge(bcc_pkg::RSN_COLD);
				end
			end
			default: ;
		endcase
		return {duty_now, stopped, kept_reason, cv_mode};
	endfunction

	function int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function bcc_pkg::item_t pack_item(input kind_t kind, input minute_t minute,
		input meas_t volt, input meas_t cur,
		input raw_t temp, input raw_t rv, input raw_t rt);
		return {kind, minute, volt, cur, temp, rv, rt};
	endfunction

	function void add_item(input bcc_pkg::item_t it, input logic typed, input outcome_t want);
		row_t row;
		row = '0;
		row.op = ROW_ITEM;
		row.it = it;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	// well-formed sample: slow minutes, drifting raw readings, measurements near targets
	function bcc_pkg::item_t make_sample();
		bcc_pkg::item_t it;
		int v, c;
		it.kind = bcc_pkg::KIND_SAMPLE;
		if ($urandom_range(0, 2) == 0) begin
			if (s_min != '1)
				s_min++;
			if ($urandom_range(0, 11) == 0)
				s_rv -= int'($urandom_range(1, 4));
			else
				s_rv += int'($urandom_range(0, 3));
			if ($urandom_range(0, 15) == 0)
				s_rt += int'($urandom_range(3, 5));
			else
				s_rt += int'($urandom_range(0, 1));
			s_rv = clamp(s_rv, 1, 1023);
			s_rt = clamp(s_rt, 1, 1023);
		end
		it.minute_count = s_min;
		it.raw_voltage = raw_t'(s_rv);
		it.raw_temp = raw_t'(s_rt);
		if (cv_mode) begin
			v = int'(limits.cv_voltage) + int'($urandom_range(0, 100)) -
				int'($urandom_range(0, 100));
			c = int'(limits.final_current) + int'($urandom_range(0, 300)) -
				int'($urandom_range(0, 60));
		end else begin
			// runs of samples at or over the limit, some long enough to trip the counter
			if (s_over > 0) begin
				s_over--;
				v = int'(limits.max_voltage) + int'($urandom_range(0, 50));
			end else if ($urandom_range(0, 9) == 0) begin
				s_over = $urandom_range(0, 5);
				v = int'(limits.max_voltage) + int'($urandom_range(0, 50));
			end else begin
				v = int'(limits.max_voltage) - int'($urandom_range(1, 400));
			end
			c = int'(limits.cc_current) - int'($urandom_range(0, 150)) +
				int'($urandom_range(0, 60));
		end
		it.batt_voltage = meas_t'(clamp(v, 0, 65535));
		it.batt_current = meas_t'(clamp(c, 0, 65535));
		if (limits.temp_min <= limits.temp_max && $urandom_range(0, 29) != 0)
			it.batt_temp = raw_t'($urandom_range(limits.temp_max, limits.temp_min));
		else
			it.batt_temp = raw_t'($urandom_range(0, 1023));
		return it;
	endfunction

	function bcc_pkg::item_t pick_item();
		bcc_pkg::item_t it;
		it.kind = kind_t'($urandom_range(0, 3));
		it.minute_count = minute_t'($urandom_range(0, 4095));
		it.batt_voltage = meas_t'($urandom_range(0, 65535));
		it.batt_current = meas_t'($urandom_range(0, 65535));
		it.batt_temp = raw_t'($urandom_range(0, 1023));
		it.raw_voltage = raw_t'($urandom_range(0, 1023));
		it.raw_temp = raw_t'($urandom_range(0, 1023));
		// one in twenty stays fully random
		if ($urandom_range(0, 19) != 0) begin
			if ((stopped && $urandom_range(0, 1) == 0) || $urandom_range(0, 79) == 0)
				it.kind = bcc_pkg::KIND_START;
			else if ($urandom_range(0, 59) == 0)
				it.kind = bcc_pkg::KIND_STOP;
			else
				it = make_sample();
		end
		if (it.kind == bcc_pkg::KIND_START) begin
			s_min = '0;
			s_rv = $urandom_range(100, 900);
			s_rt = $urandom_range(100, 900);
			s_over = 0;
		end
		return it;
	endfunction

	function bcc_pkg::cfg_t phase_settings(input int ph);
		bcc_pkg::cfg_t c;
		if (ph == 0) begin
			c = '1;
			c.chem_mode = MODE_SPARE;
		end else if (ph == 1) begin
			c = '0;
			c.chem_mode = bcc_pkg::MODE_NICKEL;
		end else begin
			case (ph)
				3, 6:    c.chem_mode = bcc_pkg::MODE_SLA;
				5:       c.chem_mode = MODE_LITHIUM;
				default: c.chem_mode = bcc_pkg::MODE_NICKEL;
			endcase
			c.timeout_minutes = minute_t'($urandom_range(8, 60));
			c.max_voltage = meas_t'($urandom_range(20000, 60000));
			c.cv_voltage = c.max_voltage - meas_t'($urandom_range(0, 2000));
			c.cc_current = meas_t'($urandom_range(200, 4000));
			c.final_current = c.cc_current / meas_t'($urandom_range(4, 10));
			c.temp_max = raw_t'($urandom_range(500, 900));
			c.temp_min = raw_t'($urandom_range(50, 300));
		end
		return c;
	endfunction

	task automatic write_settings(input bcc_pkg::cfg_t c);
		word_t word [0:bcc_pkg::CFG_TEMP_MIN];
		word[bcc_pkg::CFG_CHEM_MODE]     = word_t'(c.chem_mode);
		word[bcc_pkg::CFG_TIMEOUT]       = word_t'(c.timeout_minutes);
		word[bcc_pkg::CFG_MAX_VOLTAGE]   = c.max_voltage;
		word[bcc_pkg::CFG_CV_VOLTAGE]    = c.cv_voltage;
		word[bcc_pkg::CFG_CC_CURRENT]    = c.cc_current;
		word[bcc_pkg::CFG_FINAL_CURRENT] = c.final_current;
		word[bcc_pkg::CFG_TEMP_MAX]      = word_t'(c.temp_max);
		word[bcc_pkg::CFG_TEMP_MIN]      = word_t'(c.temp_min);
		for (int i = 0; i <= int'(bcc_pkg::CFG_TEMP_MIN); i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= idx_t'(i);
			cfg_wdata <= word[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		limits = c;
	endtask

	// hold the sender until every outcome is back, then let the pipeline settle
	task automatic drain_results();
		sample.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_item(input bcc_pkg::item_t it, input logic typed, input outcome_t want);
		outcome_t got;
		if (gap_en && $urandom_range(0, 3) == 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.kind <= it.kind;
		sample.minute_count <= it.minute_count;
		sample.batt_voltage <= it.batt_voltage;
		sample.batt_current <= it.batt_current;
		sample.batt_temp <= it.batt_temp;
		sample.raw_voltage <= it.raw_voltage;
		sample.raw_temp <= it.raw_temp;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
		got = charger_step(it);
		pending_outcomes.push_back(typed ? want : got);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result.ready <= 1'b0;
		end else if (stall_en && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 2);
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		outcome_t seen, want;
		if (arst_n && result.valid && result.ready) begin
			seen = {result.duty_out, result.stopped_out, result.end_reason, result.phase_out};
			if (pending_outcomes.size() == 0) begin
				errors++;
				$display("%0t: expected no result, got duty/stop/reason/phase %0d/%0b/%0d/%0b",
					$time, seen.duty, seen.stopped, seen.reason, seen.phase);
			end else begin
				want = pending_outcomes.pop_front();
				if (seen !== want) begin
					errors++;
					$display("%0t: expected %0d/%0b/%0d/%0b, got %0d/%0b/%0d/%0b",
						$time, want.duty, want.stopped, want.reason, want.phase,
						seen.duty, seen.stopped, seen.reason, seen.phase);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	initial begin
		while (quiet < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		row_t row;
		bcc_pkg::cfg_t lith;
		bcc_pkg::item_t it;
		int useful;

		arst_n <= 1'b0;
		sample.valid <= 1'b0;
		sample.kind <= bcc_pkg::KIND_START;
		sample.minute_count <= '0;
		sample.batt_voltage <= '0;
		sample.batt_current <= '0;
		sample.batt_temp <= '0;
		sample.raw_voltage <= '0;
		sample.raw_temp <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= bcc_pkg::CFG_CHEM_MODE;
		cfg_wdata <= '0;

		// register reset values; state comes up as after a start
		limits.chem_mode = bcc_pkg::MODE_NICKEL;
		limits.timeout_minutes = 12'd65;
		limits.max_voltage = 16'hFFFF;
		limits.cv_voltage = '0;
		limits.cc_current = '0;
		limits.final_current = '0;
		limits.temp_max = 10'h3FF;
		limits.temp_min = '0;
		void'(charger_step(pack_item(bcc_pkg::KIND_START, '0, '0, '0, '0, '0, '0)));

		// nickel mode at reset settings
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, '0, '0, '0, '0, '0, '0), 1'b1,
			{8'd0, 1'b0, bcc_pkg::RSN_NONE, 1'b0});
		repeat (3)
			add_item(pack_item(bcc_pkg::KIND_SAMPLE, '0, 16'hFFFF, '0, '0, '0, '0), 1'b1,
				{8'd0, 1'b0, bcc_pkg::RSN_NONE, 1'b0});
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, '0, 16'hFFFF, '0, '0, '0, '0), 1'b1,
			{8'd0, 1'b1, bcc_pkg::RSN_OVERVOLT, 1'b0});
		// ignored while halted; a later stop keeps the first reason
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, '0, '0, '0, '0, '0, '0), 1'b1,
			{8'd0, 1'b1, bcc_pkg::RSN_OVERVOLT, 1'b0});
		add_item(pack_item(bcc_pkg::KIND_STOP, '0, '0, '0, '0, '0, '0), 1'b1,
			{8'd0, 1'b1, bcc_pkg::RSN_OVERVOLT, 1'b0});
		add_item(pack_item(bcc_pkg::KIND_START, '0, '0, '0, '0, '0, '0), 1'b1,
			{8'd0, 1'b0, bcc_pkg::RSN_NONE, 1'b0});
		add_item(pack_item(KIND_SPARE, '1, '1, '1, '1, '1, '1), 1'b1,
			{8'd0, 1'b0, bcc_pkg::RSN_NONE, 1'b0});
		add_item(pack_item(bcc_pkg::KIND_STOP, '0, '0, '0, '0, '0, '0), 1'b1,
			{8'd0, 1'b1, bcc_pkg::RSN_USER, 1'b0});
		add_item(pack_item(bcc_pkg::KIND_START, '1, '1, '1, '1, '1, '1), 1'b1,
			{8'd0, 1'b0, bcc_pkg::RSN_NONE, 1'b0});
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, '1, '1, '1, '1, '1, '1), 1'b1,
			{8'd0, 1'b1, bcc_pkg::RSN_TIMEOUT, 1'b0});
		add_item(pack_item(bcc_pkg::KIND_START, '0, '0, '0, '0, '0, '0), 1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, 12'd1, '0, '0, 10'd300, 10'd200, 10'd100),
			1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, 12'd2, '0, '0, 10'd300, 10'd200, 10'd103),
			1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_START, '0, '0, '0, '0, '0, '0), 1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, 12'd9, '0, '0, 10'd300, 10'd300, 10'd50),
			1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, 12'd10, '0, '0, 10'd300, 10'd299, 10'd50),
			1'b0, '0);

		// lithium: constant current, switch to constant voltage, taper, temperature limits
		lith.chem_mode = MODE_LITHIUM;
		lith.timeout_minutes = 12'd65;
		lith.max_voltage = 16'd1000;
		lith.cv_voltage = 16'd900;
		lith.cc_current = 16'd500;
		lith.final_current = 16'd100;
		lith.temp_max = 10'd600;
		lith.temp_min = 10'd10;
		row = '0;
		row.op = ROW_CFG;
		row.cfg = lith;
		plan.push_back(row);
		add_item(pack_item(bcc_pkg::KIND_START, '0, '0, '0, '0, '0, '0), 1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, 12'd1, '0, '0, 10'd300, '0, '0), 1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, 12'd1, 16'd1000, '0, 10'd300, '0, '0),
			1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, 12'd2, 16'd900, 16'd50, 10'd601, '0, '0),
			1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_START, '0, '0, '0, '0, '0, '0), 1'b0, '0);
		add_item(pack_item(bcc_pkg::KIND_SAMPLE, 12'd1, '0, '0, 10'd5, '0, '0), 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < plan.size(); r++) begin
			row = plan[r];
			if (row.op == ROW_CFG) begin
				drain_results();
				write_settings(row.cfg);
			end else begin
				send_item(row.it, row.typed, row.want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			write_settings(phase_settings(ph));
			gap_en = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			stall_en = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			useful = 0;
			while (useful < PHASE_ITEMS) begin
				it = pick_item();
				// samples while halted and spare kinds change nothing
				if (!(it.kind == KIND_SPARE || (it.kind == bcc_pkg::KIND_SAMPLE && stopped)))
					useful++;
				send_item(it, 1'b0, '0);
			end
		end

		drain_results();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
